// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl file that carries checks (the top level)
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cbts_pkg.sv =====
// shared types and constants for the can bit timing solver
// no dependencies
`default_nettype none

package cbts_pkg;

  localparam int RATE_W     = 32;
  localparam int CLK_W      = 32;
  localparam int DIV_W      = 32;
  localparam int SUM_W      = 5;
  localparam int PRESC_W    = 11;
  localparam int SEG1_W     = 5;
  localparam int SEG2_W     = 4;
  localparam int WORD_W     = 23;
  localparam int OUT_DATA_W = 48;

  localparam logic [CLK_W-1:0]  CLOCK_RST   = 32'd36000000;
  localparam logic [RATE_W-1:0] RATE_MIN    = 32'd1000;
  localparam logic [RATE_W-1:0] RATE_FAST   = 32'd1000000;
  localparam logic [SUM_W-1:0]  LIMIT_FAST  = 5'd10;
  localparam logic [SUM_W-1:0]  LIMIT_SLOW  = 5'd17;
  localparam logic [SUM_W-1:0]  SUM_FLOOR   = 5'd2;
  localparam logic [DIV_W-1:0]  PRESC_MAX   = 32'd1024;
  localparam int                PERMILL_MAX = 900;
  localparam logic [SEG1_W-1:0] SEG1_MAX    = 5'd16;
  localparam logic [SUM_W-1:0]  SEG2_MAX    = 5'd8;

  typedef struct packed {
    logic load;
    logic start_whole;
    logic save_whole;
    logic start_test;
    logic dec_sum;
    logic set_fail;
    logic emit;
  } cbts_cmd_t;

  typedef struct packed {
    logic low_rate;
    logic div_done;
    logic rem_zero;
    logic sum_low;
    logic out_free;
  } cbts_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/can_bit_timing_solver.sv =====
// top level of the can bit timing solver: controller plus datapath
// depends on cbts_pkg, cbts_ctrl, cbts_dp (with cbts_div), assert_macros.svh
//
//   channel  | direction | handshake            | payload
//   in_      | sink      | in_tvalid/in_tready  | in_tdata: req_bitrate
//   out_     | source    | out_tvalid/out_tready| out_tuser: status, out_tdata: fields
//   cfg_     | sink      | cfg_wr_en            | cfg_wr_data: clock_hz
//
// one item at a time; a bitrate under 1000 gives a failed result without any divide
// otherwise one divide of clock_hz by the bitrate, then one test divide per divisor tried,
// at most 15 divisors, all on the shared restoring divider
// a finished item waits in the output register, and the next item is taken meanwhile;
// a result that meets a full output register holds the controller and the input
// synchronous active-low reset; clock_hz resets to 36000000
`default_nettype none

`include "assert_macros.svh"

module can_bit_timing_solver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // [31:0] req_bitrate
  // result item
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,   // [10:0] prescaler, [15:11] segment_one,
                                        // [19:16] segment_two, [20] jump_width,
                                        // [43:21] timing_word, [47:44] zero
  output logic             out_tuser,   // [0] status
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data  // [31:0] clock_hz
);
  import cbts_pkg::*;

  // commands from the controller, status back from the datapath
  cbts_cmd_t cmd;
  cbts_sts_t sts;

  cbts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath owns the clock register, the divider and the output register
  cbts_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .rate_in     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // a failed item carries all-zero fields
  `ASSERT_SAME(a_fail_zero, out_tvalid && out_tuser, out_tdata == '0, "failed item not zeroed")

  // a good item has its prescaler in range and the packed word agrees with it
  `ASSERT_SAME(a_presc_range, out_tvalid && !out_tuser,
               out_tdata[10:0] != 11'd0 && out_tdata[10:0] <= 11'd1024 &&
               out_tdata[30:21] == out_tdata[9:0] - 10'd1, "bad prescaler")

  // one item in flight: taking an item drops ready the next cycle
  `ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second item taken")

  // the command strobes never overlap a load with a result or a test divide
  `ASSERT_SAME(a_cmd_excl, cmd.load, !cmd.emit && !cmd.start_test, "command clash")

endmodule

`default_nettype wire

// ===== hw/rtl/cbts_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on cbts_pkg
`default_nettype none

module cbts_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [cbts_pkg::DIV_W-1:0] dividend,
  input  wire logic [cbts_pkg::DIV_W-1:0] divisor,
  output logic                           done,
  output logic [cbts_pkg::DIV_W-1:0]     quotient,
  output logic [cbts_pkg::DIV_W-1:0]     remainder
);
  import cbts_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dvs_r;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             fits;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = ~diff[DIV_W];
    rem_nxt = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done      = busy_r && (cnt_r == '1);
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cbts_dp.sv =====
// datapath: clock register, operand and sum registers, shared divider,
// segment calculation and result register; depends on cbts_pkg, cbts_div
`default_nettype none

module cbts_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cbts_pkg::cbts_cmd_t            cmd,
  output cbts_pkg::cbts_sts_t                 sts,
  input  wire logic [cbts_pkg::RATE_W-1:0]    rate_in,
  input  wire logic                           cfg_wr_en,
  input  wire logic [cbts_pkg::CLK_W-1:0]     cfg_wr_data,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [cbts_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);
  import cbts_pkg::*;

  logic [CLK_W-1:0]   clock_r;
  logic [RATE_W-1:0]  rate_r;
  logic [DIV_W-1:0]   whole_r;
  logic [SUM_W-1:0]   sum_r;
  logic               fail_r;

  logic               out_valid_r;
  logic               out_status_r;
  logic [PRESC_W-1:0] out_presc_r;
  logic [SEG1_W-1:0]  out_seg1_r;
  logic [SEG2_W-1:0]  out_seg2_r;
  logic               out_jw_r;
  logic [WORD_W-1:0]  out_word_r;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend, div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo, div_rem;

  logic [SUM_W-1:0]   sum_p1;
  logic [7:0]         sum7;
  logic [SEG1_W-1:0]  seg1_a, seg1_b, seg1;
  logic [SUM_W-1:0]   seg2;
  logic [15:0]        pm_lhs, pm_rhs;
  logic               presc_ok, seg_ok, ok;
  logic [9:0]         presc_m1;
  logic [3:0]         seg1_m1;
  logic [2:0]         seg2_m1;

  assign sum_p1       = sum_r + 5'd1;
  assign div_start    = cmd.start_whole | cmd.start_test;
  assign div_dividend = cmd.start_whole ? clock_r : whole_r;
  assign div_divisor  = cmd.start_whole ? rate_r : {{(DIV_W-SUM_W){1'b0}}, sum_p1};

  cbts_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // segment split aiming at a 7/8 sample point, pulled back above 900 permill
  always_comb begin
    sum7     = ({3'b000, sum_r} << 3) - {3'b000, sum_r};
    seg1_a   = SEG1_W'((sum7 + 8'd3) >> 3);
    seg1_b   = SEG1_W'((sum7 - 8'd1) >> 3);
    pm_lhs   = 16'd1000 * {11'b0, seg1_a + 5'd1};
    pm_rhs   = 16'(PERMILL_MAX + 1) * {11'b0, sum_p1};
    seg1     = (pm_lhs >= pm_rhs) ? seg1_b : seg1_a;
    seg2     = sum_r - seg1;
    presc_ok = (div_quo != '0) && (div_quo <= PRESC_MAX);
    seg_ok   = (seg1 != '0) && (seg1 <= SEG1_MAX) && (seg2 != '0) && (seg2 <= SEG2_MAX);
    ok       = ~fail_r & presc_ok & seg_ok;
    presc_m1 = div_quo[9:0] - 10'd1;
    seg1_m1  = seg1[3:0] - 4'd1;
    seg2_m1  = seg2[2:0] - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= CLOCK_RST;
    end else if (cfg_wr_en) begin
      clock_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_r <= 1'b0;
    end else if (cmd.load) begin
      fail_r <= 1'b0;
    end else if (cmd.set_fail) begin
      fail_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_r <= rate_in;
      sum_r  <= (rate_in >= RATE_FAST) ? (LIMIT_FAST - 5'd1) : (LIMIT_SLOW - 5'd1);
    end else if (cmd.dec_sum) begin
      sum_r <= sum_r - 5'd1;
    end
    if (cmd.save_whole) begin
      whole_r <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= ~ok;
      out_presc_r  <= ok ? div_quo[PRESC_W-1:0] : '0;
      out_seg1_r   <= ok ? seg1 : '0;
      out_seg2_r   <= ok ? seg2[SEG2_W-1:0] : '0;
      out_jw_r     <= ok;
      out_word_r   <= ok ? {seg2_m1, seg1_m1, 6'b0, presc_m1} : '0;
    end
  end

  assign sts.low_rate = rate_r < RATE_MIN;
  assign sts.div_done = div_done;
  assign sts.rem_zero = div_rem == '0;
  assign sts.sum_low  = sum_r <= SUM_FLOOR;
  assign sts.out_free = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0, out_word_r, out_jw_r, out_seg2_r, out_seg1_r, out_presc_r};

endmodule

`default_nettype wire

// ===== hw/rtl/cbts_ctrl.sv =====
// controller state machine sequencing the divide and the divisor search
// depends on cbts_pkg
`default_nettype none

module cbts_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire cbts_pkg::cbts_sts_t  sts,
  output cbts_pkg::cbts_cmd_t       cmd
);
  import cbts_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_WHOLE = 8'b0000_0100,
    S_SAVE  = 8'b0000_1000,
    S_TRY   = 8'b0001_0000,
    S_MOD   = 8'b0010_0000,
    S_EVAL  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.low_rate) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.start_whole = 1'b1;
          state_nxt       = S_WHOLE;
        end
      end
      S_WHOLE: begin
        if (sts.div_done) begin
          state_nxt = S_SAVE;
        end
      end
      S_SAVE: begin
        cmd.save_whole = 1'b1;
        state_nxt      = S_TRY;
      end
      S_TRY: begin
        cmd.start_test = 1'b1;
        state_nxt      = S_MOD;
      end
      S_MOD: begin
        if (sts.div_done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.rem_zero) begin
          state_nxt = S_EMIT;
        end else if (sts.sum_low) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.dec_sum = 1'b1;
          state_nxt   = S_TRY;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire
